// ===== src/crfp_pkg.sv =====
package crfp_pkg;

	localparam logic [5:0] FN = 6'h20;
	localparam logic [5:0] FV = 6'h10;
	localparam logic [5:0] FD = 6'h08;
	localparam logic [5:0] FI = 6'h04;
	localparam logic [5:0] FZ = 6'h02;
	localparam logic [5:0] FC = 6'h01;

	typedef enum logic [5:0] {
		K_NO, K_BRK, K_ORA, K_AND, K_EOR, K_ADC, K_SBC, K_CMP, K_CPX, K_CPY,
		K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY, K_ASL, K_ASLA, K_LSR, K_LSRA,
		K_ROL, K_ROLA, K_ROR, K_RORA, K_INC, K_INCA, K_DEC, K_DECA, K_INX, K_INY,
		K_DEX, K_DEY, K_BIT, K_BITI, K_TSB, K_BR, K_CLC, K_SEC, K_CLD, K_SED,
		K_CLI, K_SEI, K_CLV, K_PHA, K_PHP, K_PHX, K_PHY, K_PLA, K_PLP, K_PLX,
		K_PLY, K_JSR, K_RTS, K_RTI, K_TAX, K_TAY, K_TXA, K_TYA, K_TSX, K_TXS
	} op_kind_t;

	// Classified item passed from the front end to the execution unit.
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] opcode;
		logic [7:0] data;
		logic       taken;
	} item_t;

	// Result record, same order as the output stream fields.
	typedef struct packed {
		logic       mismatch;
		logic [5:0] status_known;
		logic [5:0] status_bits;
		logic       stack_valid;
		logic [7:0] stack_value;
		logic       yreg_valid;
		logic [7:0] yreg_value;
		logic       xreg_valid;
		logic [7:0] xreg_value;
		logic       acc_valid;
		logic [7:0] acc_value;
	} result_t;

	function automatic op_kind_t decode_op(input logic [7:0] op);
		op_kind_t k;
		k = K_NO;
		case (op)
			8'h00: k = K_BRK;
			8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h12, 8'h15, 8'h19, 8'h1D: k = K_ORA;
			8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h32, 8'h35, 8'h39, 8'h3D: k = K_AND;
			8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h52, 8'h55, 8'h59, 8'h5D: k = K_EOR;
			8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h72, 8'h75, 8'h79, 8'h7D: k = K_ADC;
			8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF2, 8'hF5, 8'hF9, 8'hFD: k = K_SBC;
			8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD2, 8'hD5, 8'hD9, 8'hDD: k = K_CMP;
			8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB2, 8'hB5, 8'hB9, 8'hBD: k = K_LDA;
			8'h81, 8'h85, 8'h8D, 8'h91, 8'h92, 8'h95, 8'h99, 8'h9D: k = K_STA;
			8'hE0, 8'hE4, 8'hEC: k = K_CPX;
			8'hC0, 8'hC4, 8'hCC: k = K_CPY;
			8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: k = K_LDX;
			8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: k = K_LDY;
			8'h86, 8'h8E, 8'h96: k = K_STX;
			8'h84, 8'h8C, 8'h94: k = K_STY;
			8'h06, 8'h0E, 8'h16, 8'h1E: k = K_ASL;
			8'h0A: k = K_ASLA;
			8'h46, 8'h4E, 8'h56, 8'h5E: k = K_LSR;
			8'h4A: k = K_LSRA;
			8'h26, 8'h2E, 8'h36, 8'h3E: k = K_ROL;
			8'h2A: k = K_ROLA;
			8'h66, 8'h6E, 8'h76, 8'h7E: k = K_ROR;
			8'h6A: k = K_RORA;
			8'hE6, 8'hEE, 8'hF6, 8'hFE: k = K_INC;
			8'h1A: k = K_INCA;
			8'hC6, 8'hCE, 8'hD6, 8'hDE: k = K_DEC;
			8'h3A: k = K_DECA;
			8'hE8: k = K_INX;
			8'hC8: k = K_INY;
			8'hCA: k = K_DEX;
			8'h88: k = K_DEY;
			8'h24, 8'h2C, 8'h34, 8'h3C: k = K_BIT;
			8'h89: k = K_BITI;
			8'h04, 8'h0C, 8'h14, 8'h1C: k = K_TSB;
			8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: k = K_BR;
			8'h18: k = K_CLC;
			8'h38: k = K_SEC;
			8'hD8: k = K_CLD;
			8'hF8: k = K_SED;
			8'h58: k = K_CLI;
			8'h78: k = K_SEI;
			8'hB8: k = K_CLV;
			8'h48: k = K_PHA;
			8'h08: k = K_PHP;
			8'hDA: k = K_PHX;
			8'h5A: k = K_PHY;
			8'h68: k = K_PLA;
			8'h28: k = K_PLP;
			8'hFA: k = K_PLX;
			8'h7A: k = K_PLY;
			8'h20: k = K_JSR;
			8'h60: k = K_RTS;
			8'h40: k = K_RTI;
			8'hAA: k = K_TAX;
			8'hA8: k = K_TAY;
			8'h8A: k = K_TXA;
			8'h98: k = K_TYA;
			8'hBA: k = K_TSX;
			8'h9A: k = K_TXS;
			default: k = K_NO;
		endcase
		return k;
	endfunction

endpackage

// ===== src/cpu_register_flag_predictor.sv =====
// Register and flag predictor for a 6502-family trace. Each input transaction is one
// executed instruction or interrupt entry; each produces exactly one result transaction
// giving the predicted A, X, Y, stack pointer and flags after it, plus a mismatch mark.
// One item per cycle is sustained while m_tready holds no result back: a decode register
// feeds a two-entry queue, and the execution unit updates the whole state at once into an
// output register. A result passes through the decode register, the queue entry and the
// output register before it is presented.
module cpu_register_flag_predictor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// kind
	input  logic        s_tuser,
	// opcode[7:0], operand_byte[7:0], taken, zero fill to 24 bits
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// acc_value, acc_valid, xreg_value, xreg_valid, yreg_value, yreg_valid,
	// stack_value, stack_valid, status_bits, status_known, mismatch, zero fill
	output logic [55:0] m_tdata
);

	logic            dec_valid, dec_ready, q_valid, q_ready;
	crfp_pkg::item_t dec_item, q_item;
	crfp_pkg::result_t res;

	crfp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.kind(s_tuser), .opcode(s_tdata[7:0]), .data(s_tdata[15:8]),
		.taken(s_tdata[16]),
		.dec_valid(dec_valid), .dec_ready(dec_ready), .dec_item(dec_item)
	);

	crfp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(dec_valid), .wr_ready(dec_ready), .wr_item(dec_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	crfp_exec u_exec (
		.clk(clk), .arst_n(arst_n),
		.ex_valid(q_valid), .ex_ready(q_ready), .ex_item(q_item),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tdata = {7'd0, res};

endmodule

// ===== src/crfp_front.sv =====
// Front end: takes bus-trace transactions and decodes them into item records.
module crfp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [7:0]           opcode,
	input  logic [7:0]           data,
	input  logic                 taken,
	output logic                 dec_valid,
	input  logic                 dec_ready,
	output crfp_pkg::item_t      dec_item
);

	crfp_pkg::item_t item_s1;
	logic            valid_s1;

	assign in_ready  = !valid_s1 || dec_ready;
	assign dec_valid = valid_s1;
	assign dec_item  = item_s1;

	// Decode stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.kind   <= kind ? crfp_pkg::K_BRK : crfp_pkg::decode_op(opcode);
			item_s1.opcode <= opcode;
			item_s1.data   <= data;
			item_s1.taken  <= taken;
		end
	end

endmodule

// ===== src/crfp_queue.sv =====
// Two-entry queue between the decoder and the execution unit.
module crfp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  crfp_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_ready,
	output crfp_pkg::item_t rd_item
);

	crfp_pkg::item_t mem_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_item  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

endmodule

// ===== src/crfp_exec.sv =====
// Execution unit: updates the register and flag predictions, one item per cycle while the output is not stalled.
module crfp_exec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ex_valid,
	output logic              ex_ready,
	input  crfp_pkg::item_t   ex_item,
	output logic              res_valid,
	input  logic              res_ready,
	output crfp_pkg::result_t res
);

	logic [7:0] a_q, x_q, y_q, sp_q;
	logic       a_ok_q, x_ok_q, y_ok_q, sp_ok_q;
	logic [5:0] f_q, fk_q;
	logic       res_valid_q;
	crfp_pkg::result_t res_q;

	logic [7:0] a_n, x_n, y_n, sp_n;
	logic       a_ok_n, x_ok_n, y_ok_n, sp_ok_n;
	logic [5:0] f_n, fk_n;
	logic       miss;
	logic       fire;

	assign ex_ready  = !res_valid_q || res_ready;
	assign fire      = ex_valid && ex_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Next-state logic for one item.
	always_comb begin
		logic [7:0] b;
		logic [8:0] s;
		logic [8:0] t;
		logic [7:0] bb;
		logic [5:0] st;
		logic [5:0] m;
		logic       want;
		logic       cin;
		b = ex_item.data;
		s = '0;
		t = '0;
		bb = '0;
		m = '0;
		want = 1'b0;
		cin = f_q[0];
		st = {b[7:6], b[3:0]};
		a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q;
		a_ok_n = a_ok_q; x_ok_n = x_ok_q; y_ok_n = y_ok_q; sp_ok_n = sp_ok_q;
		f_n = f_q; fk_n = fk_q;
		miss = 1'b0;
		case (ex_item.kind)
			crfp_pkg::K_BRK: begin
				if (sp_ok_q) sp_n = sp_q - 8'd3;
				miss = |((st ^ f_q) & fk_q);
				f_n = (st | crfp_pkg::FI) & ~crfp_pkg::FD;
				fk_n = 6'h3F;
			end
			crfp_pkg::K_ORA, crfp_pkg::K_AND, crfp_pkg::K_EOR: begin
				if (a_ok_q) begin
					if (ex_item.kind == crfp_pkg::K_ORA) a_n = a_q | b;
					else if (ex_item.kind == crfp_pkg::K_AND) a_n = a_q & b;
					else a_n = a_q ^ b;
					f_n[5] = a_n[7]; f_n[1] = a_n == 8'd0; fk_n = fk_q | 6'h22;
				end else fk_n = fk_q & ~6'h22;
			end
			crfp_pkg::K_ADC, crfp_pkg::K_SBC: begin
				bb = (ex_item.kind == crfp_pkg::K_SBC) ? ~b : b;
				if (a_ok_q && fk_q[0]) begin
					s = {1'b0, a_q} + {1'b0, bb} + {8'd0, cin};
					a_n = s[7:0];
					f_n[0] = s[8];
					f_n[4] = ~(a_q[7] ^ bb[7]) & (a_q[7] ^ s[7]);
					f_n[5] = s[7]; f_n[1] = s[7:0] == 8'd0;
					fk_n = fk_q | 6'h33;
				end else begin
					a_ok_n = 1'b0;
					fk_n = fk_q & ~6'h33;
				end
			end
			crfp_pkg::K_CMP, crfp_pkg::K_CPX, crfp_pkg::K_CPY: begin
				if (ex_item.kind == crfp_pkg::K_CMP) begin bb = a_q; want = a_ok_q; end
				else if (ex_item.kind == crfp_pkg::K_CPX) begin bb = x_q; want = x_ok_q; end
				else begin bb = y_q; want = y_ok_q; end
				if (want) begin
					s = {1'b0, bb} - {1'b0, b};
					f_n[0] = !s[8]; f_n[5] = s[7]; f_n[1] = s[7:0] == 8'd0;
					fk_n = fk_q | 6'h23;
				end else fk_n = fk_q & ~6'h23;
			end
			crfp_pkg::K_LDA, crfp_pkg::K_PLA, crfp_pkg::K_LDX, crfp_pkg::K_PLX,
			crfp_pkg::K_LDY, crfp_pkg::K_PLY: begin
				if (ex_item.kind == crfp_pkg::K_LDA || ex_item.kind == crfp_pkg::K_PLA) begin
					a_n = b; a_ok_n = 1'b1;
				end else if (ex_item.kind == crfp_pkg::K_LDX || ex_item.kind == crfp_pkg::K_PLX) begin
					x_n = b; x_ok_n = 1'b1;
				end else begin
					y_n = b; y_ok_n = 1'b1;
				end
				f_n[5] = b[7]; f_n[1] = b == 8'd0; fk_n = fk_q | 6'h22;
				if (sp_ok_q && (ex_item.kind == crfp_pkg::K_PLA || ex_item.kind == crfp_pkg::K_PLX
						|| ex_item.kind == crfp_pkg::K_PLY)) sp_n = sp_q + 8'd1;
			end
			crfp_pkg::K_STA, crfp_pkg::K_PHA: begin
				miss = a_ok_q && a_q != b; a_n = b; a_ok_n = 1'b1;
				if (sp_ok_q && ex_item.kind == crfp_pkg::K_PHA) sp_n = sp_q - 8'd1;
			end
			crfp_pkg::K_STX, crfp_pkg::K_PHX: begin
				miss = x_ok_q && x_q != b; x_n = b; x_ok_n = 1'b1;
				if (sp_ok_q && ex_item.kind == crfp_pkg::K_PHX) sp_n = sp_q - 8'd1;
			end
			crfp_pkg::K_STY, crfp_pkg::K_PHY: begin
				miss = y_ok_q && y_q != b; y_n = b; y_ok_n = 1'b1;
				if (sp_ok_q && ex_item.kind == crfp_pkg::K_PHY) sp_n = sp_q - 8'd1;
			end
			crfp_pkg::K_ASL, crfp_pkg::K_LSR, crfp_pkg::K_INC, crfp_pkg::K_DEC: begin
				if (ex_item.kind == crfp_pkg::K_ASL) begin
					bb = {b[6:0], 1'b0}; f_n[0] = b[7]; fk_n[0] = 1'b1;
				end else if (ex_item.kind == crfp_pkg::K_LSR) begin
					bb = {1'b0, b[7:1]}; f_n[0] = b[0]; fk_n[0] = 1'b1;
				end else if (ex_item.kind == crfp_pkg::K_INC) bb = b + 8'd1;
				else bb = b - 8'd1;
				f_n[5] = bb[7]; f_n[1] = bb == 8'd0; fk_n[5] = 1'b1; fk_n[1] = 1'b1;
			end
			crfp_pkg::K_ASLA, crfp_pkg::K_LSRA: begin
				if (a_ok_q) begin
					if (ex_item.kind == crfp_pkg::K_ASLA) begin
						a_n = {a_q[6:0], 1'b0}; f_n[0] = a_q[7];
					end else begin
						a_n = {1'b0, a_q[7:1]}; f_n[0] = a_q[0];
					end
					f_n[5] = a_n[7]; f_n[1] = a_n == 8'd0; fk_n = fk_q | 6'h23;
				end else fk_n = fk_q & ~6'h23;
			end
			crfp_pkg::K_ROL, crfp_pkg::K_ROR: begin
				if (fk_q[0]) begin
					if (ex_item.kind == crfp_pkg::K_ROL) begin
						t = {b, cin};
					end else begin
						t = {b[0], cin, b[7:1]};
					end
					f_n[0] = t[8]; f_n[5] = t[7]; f_n[1] = t[7:0] == 8'd0;
					fk_n = fk_q | 6'h23;
				end else fk_n = fk_q & ~6'h23;
			end
			crfp_pkg::K_ROLA, crfp_pkg::K_RORA: begin
				if (a_ok_q && fk_q[0]) begin
					if (ex_item.kind == crfp_pkg::K_ROLA) t = {a_q, cin};
					else t = {a_q[0], cin, a_q[7:1]};
					a_n = t[7:0];
					f_n[0] = t[8]; f_n[5] = t[7]; f_n[1] = t[7:0] == 8'd0;
					fk_n = fk_q | 6'h23;
				end else begin
					a_ok_n = 1'b0;
					fk_n = fk_q & ~6'h23;
				end
			end
			crfp_pkg::K_INCA, crfp_pkg::K_DECA: begin
				if (a_ok_q) begin
					a_n = (ex_item.kind == crfp_pkg::K_INCA) ? a_q + 8'd1 : a_q - 8'd1;
					f_n[5] = a_n[7]; f_n[1] = a_n == 8'd0; fk_n = fk_q | 6'h22;
				end else fk_n = fk_q & ~6'h22;
			end
			crfp_pkg::K_INX, crfp_pkg::K_DEX: begin
				if (x_ok_q) begin
					x_n = (ex_item.kind == crfp_pkg::K_INX) ? x_q + 8'd1 : x_q - 8'd1;
					f_n[5] = x_n[7]; f_n[1] = x_n == 8'd0; fk_n = fk_q | 6'h22;
				end else fk_n = fk_q & ~6'h22;
			end
			crfp_pkg::K_INY, crfp_pkg::K_DEY: begin
				if (y_ok_q) begin
					y_n = (ex_item.kind == crfp_pkg::K_INY) ? y_q + 8'd1 : y_q - 8'd1;
					f_n[5] = y_n[7]; f_n[1] = y_n == 8'd0; fk_n = fk_q | 6'h22;
				end else fk_n = fk_q & ~6'h22;
			end
			crfp_pkg::K_BIT, crfp_pkg::K_BITI, crfp_pkg::K_TSB: begin
				if (ex_item.kind == crfp_pkg::K_BIT) begin
					f_n[5] = b[7]; f_n[4] = b[6]; fk_n[5] = 1'b1; fk_n[4] = 1'b1;
				end
				f_n[1] = (a_q & b) == 8'd0;
				fk_n[1] = a_ok_q;
			end
			crfp_pkg::K_BR: begin
				case (ex_item.opcode[7:6])
					2'd0: m = crfp_pkg::FN;
					2'd1: m = crfp_pkg::FV;
					2'd2: m = crfp_pkg::FC;
					default: m = crfp_pkg::FZ;
				endcase
				want = ex_item.taken ? ex_item.opcode[5] : !ex_item.opcode[5];
				if (|(fk_q & m)) miss = (|(f_q & m)) != want;
				else begin
					f_n = want ? (f_q | m) : (f_q & ~m);
					fk_n = fk_q | m;
				end
			end
			crfp_pkg::K_CLC: begin f_n[0] = 1'b0; fk_n[0] = 1'b1; end
			crfp_pkg::K_SEC: begin f_n[0] = 1'b1; fk_n[0] = 1'b1; end
			crfp_pkg::K_CLD: begin f_n[3] = 1'b0; fk_n[3] = 1'b1; end
			crfp_pkg::K_SED: begin f_n[3] = 1'b1; fk_n[3] = 1'b1; end
			crfp_pkg::K_CLI: begin f_n[2] = 1'b0; fk_n[2] = 1'b1; end
			crfp_pkg::K_SEI: begin f_n[2] = 1'b1; fk_n[2] = 1'b1; end
			crfp_pkg::K_CLV: begin f_n[4] = 1'b0; fk_n[4] = 1'b1; end
			crfp_pkg::K_PHP: begin
				if (sp_ok_q) sp_n = sp_q - 8'd1;
				miss = |((st ^ f_q) & fk_q);
				f_n = st; fk_n = 6'h3F;
			end
			crfp_pkg::K_PLP: begin
				if (sp_ok_q) sp_n = sp_q + 8'd1;
				f_n = st; fk_n = 6'h3F;
			end
			crfp_pkg::K_RTI: begin
				if (sp_ok_q) sp_n = sp_q + 8'd3;
				f_n = st; fk_n = 6'h3F;
			end
			crfp_pkg::K_JSR: if (sp_ok_q) sp_n = sp_q - 8'd2;
			crfp_pkg::K_RTS: if (sp_ok_q) sp_n = sp_q + 8'd2;
			crfp_pkg::K_TAX, crfp_pkg::K_TAY, crfp_pkg::K_TXA, crfp_pkg::K_TYA,
			crfp_pkg::K_TSX: begin
				case (ex_item.kind)
					crfp_pkg::K_TAX, crfp_pkg::K_TAY: begin bb = a_q; want = a_ok_q; end
					crfp_pkg::K_TXA: begin bb = x_q; want = x_ok_q; end
					crfp_pkg::K_TYA: begin bb = y_q; want = y_ok_q; end
					default: begin bb = sp_q; want = sp_ok_q; end
				endcase
				if (want) begin
					case (ex_item.kind)
						crfp_pkg::K_TAX, crfp_pkg::K_TSX: begin x_n = bb; x_ok_n = 1'b1; end
						crfp_pkg::K_TAY: begin y_n = bb; y_ok_n = 1'b1; end
						default: begin a_n = bb; a_ok_n = 1'b1; end
					endcase
					f_n[5] = bb[7]; f_n[1] = bb == 8'd0; fk_n = fk_q | 6'h22;
				end else fk_n = fk_q & ~6'h22;
			end
			crfp_pkg::K_TXS: if (x_ok_q) begin sp_n = x_q; sp_ok_n = 1'b1; end
			default: ;
		endcase
	end

	// Architectural state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= '0; f_q <= '0;
			a_ok_q <= 1'b0; x_ok_q <= 1'b0; y_ok_q <= 1'b0; sp_ok_q <= 1'b0; fk_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ex_ready) res_valid_q <= ex_valid;
			if (fire) begin
				a_q <= a_n; x_q <= x_n; y_q <= y_n; sp_q <= sp_n; f_q <= f_n;
				a_ok_q <= a_ok_n; x_ok_q <= x_ok_n; y_ok_q <= y_ok_n; sp_ok_q <= sp_ok_n;
				fk_q <= fk_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.acc_value    <= a_ok_n ? a_n : 8'd0;
			res_q.acc_valid    <= a_ok_n;
			res_q.xreg_value   <= x_ok_n ? x_n : 8'd0;
			res_q.xreg_valid   <= x_ok_n;
			res_q.yreg_value   <= y_ok_n ? y_n : 8'd0;
			res_q.yreg_valid   <= y_ok_n;
			res_q.stack_value  <= sp_ok_n ? sp_n : 8'd0;
			res_q.stack_valid  <= sp_ok_n;
			res_q.status_bits  <= f_n & fk_n;
			res_q.status_known <= fk_n;
			res_q.mismatch     <= miss;
		end
	end

endmodule

// ===== src/crfp_checker.sv =====
// Port-level checks on the predictor.
module crfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// A result held under backpressure keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Unknown values read as zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8] || m_tdata[7:0] == 8'd0)
			&& (m_tdata[17] || m_tdata[16:9] == 8'd0)
			&& (m_tdata[26] || m_tdata[25:18] == 8'd0)
			&& (m_tdata[35] || m_tdata[34:27] == 8'd0))
		else $error("unknown register shows a value");

	// Flag bits only where known.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[41:36] & ~m_tdata[47:42]) == 6'd0)
		else $error("unknown flag shows a value");

	// No result appears without input, straight after reset.
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
		else $error("result out of reset");

endmodule

bind cpu_register_flag_predictor crfp_checker u_crfp_checker (.*);
